@@ design/rbis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbis_pkg: shared definitions for the ROM byte interleave scatter block
// Register map, configuration bundle, queue entry format and the small
// helpers that clamp the stride and the group size.
// ----------------------------------------------------------------------------
package rbis_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int IDX_W             = 28;
  localparam int OFFSET_W          = 28;
  localparam int ADDR_W            = 5;
  localparam int DATA_W            = 32;

  localparam logic [4:0] MAX_GAP     = 5'd16;
  localparam logic [3:0] MAX_GROUP   = 4'd15;
  localparam logic [7:0] INVERT_MASK = 8'hff;
  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  typedef enum logic [2:0] {
    REG_GAP           = 3'd0,
    REG_GROUP_SIZE    = 3'd1,
    REG_REVERSE_GROUP = 3'd2,
    REG_SWAP_BYTES    = 3'd3,
    REG_INVERT_BITS   = 3'd4,
    REG_NIBBLE_SPLIT  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [4:0] gap;
    logic [3:0] group_size;
    logic       reverse_group;
    logic       swap_bytes;
    logic       invert_bits;
    logic       nibble_split;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_COPY,
    MODE_GROUP,
    MODE_NIBBLE
  } write_mode_t;

  typedef struct packed {
    write_mode_t      mode;
    logic [IDX_W-1:0] idx;
    logic [3:0]       off;
    logic [7:0]       value;
    logic             final_byte;
  } entry_t;

  function automatic logic [4:0] gap_eff(input logic [4:0] gap);
    if (gap > MAX_GAP) return MAX_GAP;
    return gap;
  endfunction

  function automatic logic [3:0] group_eff(input logic [3:0] group_size);
    if (group_size == 4'd0) return 4'd1;
    if (group_size > MAX_GROUP) return MAX_GROUP;
    return group_size;
  endfunction

endpackage
`default_nettype wire

@@ design/rbis_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbis_if: streaming channels of the ROM byte interleave scatter block
// Input channel carries source bytes, output channel carries destination
// writes. Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rom_byte;
  logic       final_byte;

  modport source(output valid, rom_byte, final_byte, input ready);
  modport sink(input valid, rom_byte, final_byte, output ready);
endinterface

interface rbis_out_if import rbis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] dest_offset;
  logic [7:0]          dest_value;
  logic                last_write;

  modport source(output valid, dest_offset, dest_value, last_write, input ready);
  modport sink(input valid, dest_offset, dest_value, last_write, output ready);
endinterface
`default_nettype wire

@@ design/rbis_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbis_regs: APB configuration registers
// Six control registers at word addresses; writes complete in the access
// phase and reads return the current register value.
// ----------------------------------------------------------------------------
module rbis_regs import rbis_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              group_size_wr
);

  logic       wr_en;
  reg_index_t reg_idx;

  assign pready        = 1'b1;
  assign wr_en         = psel & penable & pwrite;
  assign reg_idx       = reg_index_t'(paddr[ADDR_W-1:2]);
  assign group_size_wr = wr_en && (reg_idx == REG_GROUP_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap           <= 5'd1;
      cfg.group_size    <= 4'd0;
      cfg.reverse_group <= 1'b0;
      cfg.swap_bytes    <= 1'b0;
      cfg.invert_bits   <= 1'b0;
      cfg.nibble_split  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAP:           cfg.gap           <= pwdata[4:0];
        REG_GROUP_SIZE:    cfg.group_size    <= pwdata[3:0];
        REG_REVERSE_GROUP: cfg.reverse_group <= pwdata[0];
        REG_SWAP_BYTES:    cfg.swap_bytes    <= pwdata[0];
        REG_INVERT_BITS:   cfg.invert_bits   <= pwdata[0];
        REG_NIBBLE_SPLIT:  cfg.nibble_split  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAP:           prdata = DATA_W'(cfg.gap);
      REG_GROUP_SIZE:    prdata = DATA_W'(cfg.group_size);
      REG_REVERSE_GROUP: prdata = DATA_W'(cfg.reverse_group);
      REG_SWAP_BYTES:    prdata = DATA_W'(cfg.swap_bytes);
      REG_INVERT_BITS:   prdata = DATA_W'(cfg.invert_bits);
      REG_NIBBLE_SPLIT:  prdata = DATA_W'(cfg.nibble_split);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/rbis_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbis_front: source byte intake and classification
// Tracks the source position with a running quotient and remainder by the
// group size, derives the swapped position's group and offset, and queues
// one entry per accepted byte. A shift-subtract divider rebuilds the
// quotient and remainder after the group size changes.
// ----------------------------------------------------------------------------
module rbis_front import rbis_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  rbis_in_if.sink byte_in,
  input  cfg_t   cfg,
  input  logic   group_size_wr,
  input  logic   full,
  output logic   push,
  output entry_t push_entry
);

  localparam int CNT_W = $clog2(POSITION_BITS + 1);
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] quo;
  logic [3:0]               rem;
  logic                     div_busy;
  logic [CNT_W-1:0]         div_cnt;
  logic [POSITION_BITS-1:0] div_dvd;

  logic                     acc;
  logic [3:0]               gs;
  logic [3:0]               gs_m1;
  logic [4:0]               trial;
  logic [4:0]               trial_diff;
  logic                     div_bit;
  logic [3:0]               div_rem_next;
  logic [POSITION_BITS-1:0] s;
  logic [POSITION_BITS-1:0] qs;
  logic [3:0]               ks;
  logic [3:0]               off;

  assign byte_in.ready = !div_busy && !full;
  assign acc           = byte_in.valid && byte_in.ready;
  assign push          = acc;

  assign gs    = group_eff(cfg.group_size);
  assign gs_m1 = gs - 4'd1;

  // One quotient bit per cycle, dividend taken MSB first.
  assign trial        = {rem, div_dvd[POSITION_BITS-1]};
  assign trial_diff   = trial - {1'b0, gs};
  assign div_bit      = trial >= {1'b0, gs};
  assign div_rem_next = div_bit ? trial_diff[3:0] : trial[3:0];

  // The swapped position differs from the tracked one by exactly one, so its
  // group and offset follow from a single step of the remainder.
  always_comb begin
    s  = pos ^ {{(POSITION_BITS-1){1'b0}}, cfg.swap_bytes};
    qs = quo;
    ks = rem;
    if (cfg.swap_bytes) begin
      if (!pos[0]) begin
        if (rem == gs_m1) begin
          qs = quo + POS_ONE;
          ks = 4'd0;
        end else begin
          ks = rem + 4'd1;
        end
      end else begin
        if (rem == 4'd0) begin
          qs = quo - POS_ONE;
          ks = gs_m1;
        end else begin
          ks = rem - 4'd1;
        end
      end
    end
    off = cfg.reverse_group ? (gs_m1 - ks) : ks;
  end

  always_comb begin
    push_entry.value      = byte_in.rom_byte ^ (cfg.invert_bits ? INVERT_MASK : 8'h00);
    push_entry.final_byte = byte_in.final_byte;
    if (cfg.nibble_split) begin
      push_entry.mode = MODE_NIBBLE;
      push_entry.idx  = IDX_W'(s);
      push_entry.off  = 4'd0;
    end else if (gap_eff(cfg.gap) <= 5'd1) begin
      push_entry.mode = MODE_COPY;
      push_entry.idx  = IDX_W'(s);
      push_entry.off  = 4'd0;
    end else begin
      push_entry.mode = MODE_GROUP;
      push_entry.idx  = IDX_W'(qs);
      push_entry.off  = off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      quo      <= '0;
      rem      <= 4'd0;
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (group_size_wr) begin
      div_busy <= 1'b1;
      div_cnt  <= CNT_W'(POSITION_BITS);
      div_dvd  <= pos;
      quo      <= '0;
      rem      <= 4'd0;
    end else if (div_busy) begin
      quo     <= {quo[POSITION_BITS-2:0], div_bit};
      rem     <= div_rem_next;
      div_dvd <= div_dvd << 1;
      div_cnt <= div_cnt - CNT_W'(1);
      if (div_cnt == CNT_W'(1)) begin
        div_busy <= 1'b0;
      end
    end else if (acc) begin
      if (byte_in.final_byte) begin
        pos <= '0;
        quo <= '0;
        rem <= 4'd0;
      end else begin
        pos <= pos + POS_ONE;
        // The position wraps to zero, and the group count with it.
        if (&pos) begin
          quo <= '0;
          rem <= 4'd0;
        end else if (rem == gs_m1) begin
          quo <= quo + POS_ONE;
          rem <= 4'd0;
        end else begin
          rem <= rem + 4'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_group: assert property (@(posedge clk) disable iff (rst)
    !div_busy |-> (rem < gs))
    else $error("running remainder not below the group size");

  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    (acc && byte_in.final_byte && !group_size_wr) |=> (pos == '0 && quo == '0 && rem == 4'd0))
    else $error("position state not cleared after the final byte");
`endif

endmodule
`default_nettype wire

@@ design/rbis_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbis_fifo: two-entry queue between intake and write generation
// Register-based first-in first-out buffer of classified source bytes.
// ----------------------------------------------------------------------------
module rbis_fifo import rbis_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/rbis_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbis_back: destination write generation
// Turns each queued entry into one write (copy or grouped) or two nibble
// writes, and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module rbis_back import rbis_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  entry_t head,
  input  logic   empty,
  output logic   pop,
  rbis_out_if.source write_out
);

  localparam int PROD_W = POSITION_BITS + 5;
  localparam int SUM_W  = (PROD_W + 1 > OFFSET_W) ? PROD_W + 1 : OFFSET_W;

  logic                     phase;
  logic                     load;
  logic [POSITION_BITS-1:0] idx;
  logic [PROD_W-1:0]        prod;
  logic [SUM_W-1:0]         sum;
  logic [3:0]               nib;
  logic [7:0]               val;
  logic                     last;

  assign idx  = head.idx[POSITION_BITS-1:0];
  assign prod = PROD_W'(idx) * PROD_W'(gap_eff(cfg.gap));
  assign load = !empty && (!write_out.valid || write_out.ready);
  assign nib  = (phase ? head.value[7:4] : head.value[3:0]) & NIBBLE_MASK;
  // A nibble entry stays at the head of the queue until its high half is out.
  assign pop  = load && ((head.mode != MODE_NIBBLE) || phase);

  always_comb begin
    case (head.mode)
      MODE_GROUP: begin
        sum  = SUM_W'(prod) + SUM_W'(head.off);
        val  = head.value;
        last = head.final_byte;
      end
      MODE_NIBBLE: begin
        sum  = SUM_W'({idx, 1'b0}) + SUM_W'(phase);
        val  = {4'd0, nib};
        last = head.final_byte & phase;
      end
      default: begin
        sum  = SUM_W'(idx);
        val  = head.value;
        last = head.final_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_out.valid <= 1'b0;
      phase           <= 1'b0;
    end else if (load) begin
      write_out.valid       <= 1'b1;
      write_out.dest_offset <= sum[OFFSET_W-1:0];
      write_out.dest_value  <= val;
      write_out.last_write  <= last;
      phase                 <= (head.mode == MODE_NIBBLE) && !phase;
    end else if (write_out.ready) begin
      write_out.valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_phase_on_nibble: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!empty && head.mode == MODE_NIBBLE))
    else $error("second nibble pending without a nibble entry at the head");

  a_nibble_holds_entry: assert property (@(posedge clk) disable iff (rst)
    (load && head.mode == MODE_NIBBLE && !phase) |=> (phase && !empty))
    else $error("nibble entry left the queue before its high half");
`endif

endmodule
`default_nettype wire

@@ design/rom_byte_interleave_scatter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rom_byte_interleave_scatter: ROM image byte scatter into interleaved memory
// Accepts source image bytes in order and emits destination writes (offset,
// value) that place them by group, stride, reversal, swap and nibble split.
// ----------------------------------------------------------------------------
// In byte mode the block takes one source byte per clock and gives one write
// per clock while the output takes each write and the divider is idle; in
// nibble mode each byte yields two writes, so the output port sets the pace.
// Intake and write generation are separated by a two-entry queue and the write
// sits in an output register, so either side may stall without blocking the
// other. After a write to group_size the input is held off while a
// one-bit-per-cycle divider rebuilds the current group index and offset of the
// source position.
module rom_byte_interleave_scatter import rbis_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  rbis_in_if.sink           byte_in,
  rbis_out_if.source        write_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  logic   group_size_wr;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  entry_t push_entry;
  entry_t head;

  rbis_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cfg           (cfg),
    .group_size_wr (group_size_wr)
  );

  rbis_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_in       (byte_in),
    .cfg           (cfg),
    .group_size_wr (group_size_wr),
    .full          (full),
    .push          (push),
    .push_entry    (push_entry)
  );

  rbis_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  rbis_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .write_out (write_out)
  );

endmodule
`default_nettype wire
